>>> hdl/pvp_pkg.sv
package pvp_pkg;

  // Field and datapath widths.
  localparam int CoefW      = 16;
  localparam int PtW        = 20;
  localparam int ProdW      = CoefW + PtW;
  localparam int AccW       = 38;
  localparam int CamW       = 26;
  localparam int MagW       = 26;
  localparam int FracW      = 16;
  localparam int DvdW       = MagW + FracW;
  localparam int DivBits    = 6;
  localparam int DivStages  = DvdW / DivBits;
  localparam int SclW       = 32;
  localparam int UW         = 45;
  localparam int UMagW      = UW - 1;
  localparam int HalfW      = UMagW / 2;
  localparam int PartW      = HalfW + SclW;
  localparam int FullW      = UMagW + SclW + 1;
  localparam int RW         = 41;
  localparam int FinW       = 44;
  localparam int PipeStages = 7 + DivStages;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    CFG_ROW_X  = 3'd0,
    CFG_ROW_Y  = 3'd1,
    CFG_ROW_Z  = 3'd2,
    CFG_TRANS  = 3'd3,
    CFG_SCALE  = 3'd4,
    CFG_OFFSET = 3'd5,
    CFG_HEIGHT = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [PtW-1:0] point_x;
    logic signed [PtW-1:0] point_y;
    logic signed [PtW-1:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [31:0]    viewport_x;
    logic signed [31:0]    viewport_y;
    logic signed [PtW-1:0] camera_depth;
    logic                  depth_zero;
  } proj_t;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [FinW-1:0] v);
    logic signed [31:0] r;
    if (v > 44'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -44'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Saturate a camera coordinate to the depth field width.
  function automatic logic signed [PtW-1:0] sat_depth(input logic signed [CamW-1:0] v);
    logic signed [PtW-1:0] r;
    if (v > 26'sd524287) begin
      r = 20'sh7ffff;
    end else if (v < -26'sd524288) begin
      r = 20'sh80000;
    end else begin
      r = v[PtW-1:0];
    end
    return r;
  endfunction

endpackage

>>> hdl/pvp_div.sv
// Pipelined unsigned restoring divider, a fixed number of quotient bits per stage.
module pvp_div (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic [pvp_pkg::DvdW-1:0]         dividend_i,
  input  logic [pvp_pkg::MagW-1:0]         divisor_i,
  output logic [pvp_pkg::DvdW-1:0]         quot_o
);

  logic [pvp_pkg::MagW-1:0] rem_s [0:pvp_pkg::DivStages];
  logic [pvp_pkg::DvdW-1:0] num_s [0:pvp_pkg::DivStages];
  logic [pvp_pkg::DvdW-1:0] quo_s [0:pvp_pkg::DivStages];
  logic [pvp_pkg::MagW-1:0] den_s [0:pvp_pkg::DivStages];

  // The first stage starts from an empty remainder.
  assign rem_s[0] = '0;
  assign num_s[0] = dividend_i;
  assign quo_s[0] = '0;
  assign den_s[0] = divisor_i;

  for (genvar k = 0; k < pvp_pkg::DivStages; k++) begin : g_stage
    logic [pvp_pkg::MagW-1:0] rem_d;
    logic [pvp_pkg::DvdW-1:0] num_d;
    logic [pvp_pkg::DvdW-1:0] quo_d;
    logic [pvp_pkg::MagW-1:0] rem_q;
    logic [pvp_pkg::DvdW-1:0] num_q;
    logic [pvp_pkg::DvdW-1:0] quo_q;
    logic [pvp_pkg::MagW-1:0] den_q;

    // Shift in one dividend bit per step and subtract when the divisor fits.
    always_comb begin
      logic [pvp_pkg::MagW:0] trial;
      rem_d = rem_s[k];
      num_d = num_s[k];
      quo_d = quo_s[k];
      for (int i = 0; i < pvp_pkg::DivBits; i++) begin
        trial = {rem_d, num_d[pvp_pkg::DvdW-1]};
        num_d = {num_d[pvp_pkg::DvdW-2:0], 1'b0};
        if (trial >= {1'b0, den_s[k]}) begin
          trial = trial - {1'b0, den_s[k]};
          quo_d = {quo_d[pvp_pkg::DvdW-2:0], 1'b1};
        end else begin
          quo_d = {quo_d[pvp_pkg::DvdW-2:0], 1'b0};
        end
        rem_d = trial[pvp_pkg::MagW-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q <= rem_d;
        num_q <= num_d;
        quo_q <= quo_d;
        den_q <= den_s[k];
      end
    end

    assign rem_s[k+1] = rem_q;
    assign num_s[k+1] = num_q;
    assign quo_s[k+1] = quo_q;
    assign den_s[k+1] = den_q;
  end

  assign quot_o = quo_s[pvp_pkg::DivStages];

endmodule

>>> hdl/point_to_viewport_projection.sv
// Perspective point transform and viewport mapping.
// Points enter on the input channel (in_valid_i, in_ready_o, in_point_i) as
// signed Q11.8 coordinates. Each point is transformed by the configured 3x3
// matrix plus translation, divided by the negated camera depth, offset,
// scaled to pixels and flipped in y. Results leave on the output channel
// (out_valid_o, out_ready_i, out_proj_o) in the order the points came in.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_wdata_i and
// must only change while no transaction is in flight.
// Throughput is one point per cycle while the receiver does not stall; the
// pipeline depth is set mostly by the seven-stage divider that forms the
// two ratios, six quotient bits per stage.
// Reset loads the identity matrix and clears the other configuration
// registers and the pipeline valid bits. When the receiver stalls, the whole
// pipeline holds and in_ready_o drops until the waiting result is taken,
// unless the output stage is empty.
module point_to_viewport_projection (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [63:0]           cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pvp_pkg::point_t       in_point_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output pvp_pkg::proj_t        out_proj_o
);

  localparam int NStg = pvp_pkg::PipeStages;
  localparam int DivLast = 3 + pvp_pkg::DivStages;

  // Configuration registers.
  logic [47:0] row_q [0:2];
  logic [59:0] trans_q;
  logic [63:0] scale_q;
  logic [63:0] offset_q;
  logic [15:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= 48'h0000_0000_1000;
      row_q[1] <= 48'h0000_1000_0000;
      row_q[2] <= 48'h1000_0000_0000;
      trans_q  <= '0;
      scale_q  <= '0;
      offset_q <= '0;
      height_q <= '0;
    end else if (cfg_we_i) begin
      case (pvp_pkg::cfg_idx_e'(cfg_idx_i))
        pvp_pkg::CFG_ROW_X:  row_q[0] <= cfg_wdata_i[47:0];
        pvp_pkg::CFG_ROW_Y:  row_q[1] <= cfg_wdata_i[47:0];
        pvp_pkg::CFG_ROW_Z:  row_q[2] <= cfg_wdata_i[47:0];
        pvp_pkg::CFG_TRANS:  trans_q  <= cfg_wdata_i[59:0];
        pvp_pkg::CFG_SCALE:  scale_q  <= cfg_wdata_i;
        pvp_pkg::CFG_OFFSET: offset_q <= cfg_wdata_i;
        pvp_pkg::CFG_HEIGHT: height_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // Global advance: the pipeline moves unless the output is full and stalled.
  logic adv;
  logic [NStg-1:0] v_q;

  assign adv         = ~v_q[NStg-1] | out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = v_q[NStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NStg-2:0], in_valid_i};
    end
  end

  // Stage 1: the nine matrix products.
  logic signed [pvp_pkg::PtW-1:0]   pt [0:2];
  logic signed [pvp_pkg::ProdW-1:0] prod_q [0:2][0:2];

  assign pt[0] = in_point_i.point_x;
  assign pt[1] = in_point_i.point_y;
  assign pt[2] = in_point_i.point_z;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int j = 0; j < 3; j++) begin
          prod_q[r][j] <= $signed(row_q[r][16*j +: 16]) * pt[j];
        end
      end
    end
  end

  // Stage 2: sum with translation and round to Q.8, ties upward.
  logic signed [pvp_pkg::CamW-1:0] cam_d [0:2];
  logic signed [pvp_pkg::CamW-1:0] cam_q [0:2];

  always_comb begin
    logic signed [pvp_pkg::AccW-1:0] acc;
    logic signed [19:0]              t;
    for (int r = 0; r < 3; r++) begin
      t   = $signed(trans_q[20*r +: 20]);
      acc = pvp_pkg::AccW'(prod_q[r][0]) + pvp_pkg::AccW'(prod_q[r][1])
          + pvp_pkg::AccW'(prod_q[r][2]) + $signed({{6{t[19]}}, t, 12'b0})
          + 38'sd2048;
      cam_d[r] = acc[pvp_pkg::AccW-1:12];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cam_q <= cam_d;
    end
  end

  // Stage 3: magnitudes for the divider and the quotient signs.
  typedef struct packed {
    logic                    neg_x;
    logic                    neg_y;
    logic                    zero;
    logic [pvp_pkg::PtW-1:0] depth;
  } side_t;

  logic [pvp_pkg::DvdW-1:0] dvd_q [0:1];
  logic [pvp_pkg::MagW-1:0] den_q;
  side_t                    s3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        dvd_q[l] <= {(cam_q[l][pvp_pkg::CamW-1] ? pvp_pkg::MagW'(-cam_q[l])
                                                : pvp_pkg::MagW'(cam_q[l])),
                     {pvp_pkg::FracW{1'b0}}};
      end
      den_q <= cam_q[2][pvp_pkg::CamW-1] ? pvp_pkg::MagW'(-cam_q[2])
                                         : pvp_pkg::MagW'(cam_q[2]);
      s3_q.neg_x <= ~(cam_q[0][pvp_pkg::CamW-1] ^ cam_q[2][pvp_pkg::CamW-1]);
      s3_q.neg_y <= ~(cam_q[1][pvp_pkg::CamW-1] ^ cam_q[2][pvp_pkg::CamW-1]);
      s3_q.zero  <= (cam_q[2] == '0);
      s3_q.depth <= pvp_pkg::sat_depth(cam_q[2]);
    end
  end

  // Divider stages, with side data traveling alongside.
  logic [pvp_pkg::DvdW-1:0] quo [0:1];
  side_t                    sd_q [0:pvp_pkg::DivStages-1];

  for (genvar l = 0; l < 2; l++) begin : g_div
    pvp_div u_div (
      .clk_i      (clk_i),
      .en_i       (adv),
      .dividend_i (dvd_q[l]),
      .divisor_i  (den_q),
      .quot_o     (quo[l])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd_q[0] <= s3_q;
      for (int k = 1; k < pvp_pkg::DivStages; k++) begin
        sd_q[k] <= sd_q[k-1];
      end
    end
  end

  // Stage 4: signed ratio plus image-plane offset, split into sign and size.
  logic [pvp_pkg::UMagW-1:0] umag_q [0:1];
  logic                      uneg_q [0:1];
  side_t                     s4_q;

  always_ff @(posedge clk_i) begin
    logic signed [pvp_pkg::UW-1:0] q;
    logic signed [pvp_pkg::UW-1:0] u;
    logic                          qn;
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        qn = (l == 0) ? sd_q[pvp_pkg::DivStages-1].neg_x : sd_q[pvp_pkg::DivStages-1].neg_y;
        q  = $signed({3'b000, quo[l]});
        if (qn) begin
          q = -q;
        end
        u = q + $signed({13'b0, offset_q[32*l +: 32]});
        uneg_q[l] <= u[pvp_pkg::UW-1];
        umag_q[l] <= u[pvp_pkg::UW-1] ? pvp_pkg::UMagW'(-u) : pvp_pkg::UMagW'(u);
      end
      s4_q <= sd_q[pvp_pkg::DivStages-1];
    end
  end

  // Stage 5: partial products of the magnitude and the pixel scale.
  logic [pvp_pkg::PartW-1:0] plo_q [0:1];
  logic [pvp_pkg::PartW-1:0] phi_q [0:1];
  logic                      neg5_q [0:1];
  side_t                     s5_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        plo_q[l]  <= umag_q[l][pvp_pkg::HalfW-1:0] * scale_q[32*l +: 32];
        phi_q[l]  <= umag_q[l][pvp_pkg::UMagW-1:pvp_pkg::HalfW] * scale_q[32*l +: 32];
        neg5_q[l] <= uneg_q[l];
      end
      s5_q <= s4_q;
    end
  end

  // Stage 6: full product, round half away from zero, clamp to 2^40.
  logic [pvp_pkg::RW-1:0] r_q [0:1];
  logic                   neg6_q [0:1];
  side_t                  s6_q;

  always_ff @(posedge clk_i) begin
    logic [pvp_pkg::FullW-1:0] p;
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        p = {phi_q[l], {pvp_pkg::HalfW{1'b0}}} + pvp_pkg::FullW'(plo_q[l])
          + pvp_pkg::FullW'(32768);
        if (p[pvp_pkg::FullW-1:16] > pvp_pkg::FullW'(64'h100_0000_0000)) begin
          r_q[l] <= 41'h100_0000_0000;
        end else begin
          r_q[l] <= p[16 +: pvp_pkg::RW];
        end
        neg6_q[l] <= neg5_q[l];
      end
      s6_q <= s5_q;
    end
  end

  // Stage 7: restore signs, flip y against the height and saturate; zero depth gives zero coordinates.
  pvp_pkg::proj_t out_q;

  always_ff @(posedge clk_i) begin
    logic signed [pvp_pkg::FinW-1:0] sx;
    logic signed [pvp_pkg::FinW-1:0] sy;
    if (adv) begin
      sx = $signed({3'b000, r_q[0]});
      sy = $signed({3'b000, r_q[1]});
      if (neg6_q[0]) begin
        sx = -sx;
      end
      if (neg6_q[1]) begin
        sy = -sy;
      end
      if (s6_q.zero) begin
        out_q.viewport_x <= '0;
        out_q.viewport_y <= '0;
      end else begin
        out_q.viewport_x <= pvp_pkg::sat32(sx);
        out_q.viewport_y <= pvp_pkg::sat32($signed({12'b0, height_q, 16'b0}) - sy);
      end
      out_q.camera_depth <= s6_q.depth;
      out_q.depth_zero   <= s6_q.zero;
    end
  end

  assign out_proj_o = out_q;

  // A zero-depth result carries zero coordinates and zero depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_proj_o.depth_zero |->
      out_proj_o.viewport_x == '0 && out_proj_o.viewport_y == '0 &&
      out_proj_o.camera_depth == '0)
    else $error("zero depth result with nonzero fields");

  // The input is only held off while a finished result waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without an output stall");

  // An accepted transaction occupies the first stage on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v_q[0])
    else $error("accepted transaction lost at entry");

  // The divider output stage and the stage after it move together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && v_q[DivLast-1] |=> v_q[DivLast])
    else $error("valid bit lost after the divider");

endmodule
